### src/markov_drum_trigger_generator_unit_assert.svh
// Assertion macros used by the checker file of the drum trigger generator.
`ifndef MARKOV_DRUM_TRIGGER_GENERATOR_UNIT_ASSERT_SVH
`define MARKOV_DRUM_TRIGGER_GENERATOR_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is low
`define MDTG_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is low
`define MDTG_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/mdtg_pkg.sv
// Package of the drum trigger generator: item types, Q24 constants, probability tables.
`default_nettype none

package mdtg_pkg;

	// Configuration port
	localparam int unsigned CFG_IDX_W  = 1;
	localparam int unsigned CFG_DATA_W = 17;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_KICK_DENSITY   = 1'b0,
		REG_HAT_COMPLEXITY = 1'b1
	} cfg_reg_e;

	localparam logic [16:0] KNOB_MAX           = 17'd65536;
	localparam logic [16:0] KICK_DENSITY_RST   = 17'd40632;
	localparam logic [16:0] HAT_COMPLEXITY_RST = 17'd38011;

	// Cycles from a knob write until the derived tables are valid
	localparam logic [2:0] SETTLE_CYCLES = 3'd4;

	// Generator constants
	localparam logic [31:0] GEN_RESET = 32'h4D59_5DF4;
	localparam logic [31:0] MIX_XOR   = 32'hA341_316C;
	localparam logic [31:0] LCG_MUL   = 32'd1664525;
	localparam logic [31:0] LCG_ADD   = 32'd1013904223;

	// Q24 constants
	localparam logic [24:0] Q_ONE        = 25'h100_0000;
	localparam logic [23:0] C_K_DENS_OFF = 24'd1342177;
	localparam logic [23:0] C_K_DENS_MUL = 24'd14428406;
	localparam logic [23:0] C_K_ACCENT   = 24'd2348810;
	localparam logic [23:0] C_K_DENS     = 24'd7381975;
	localparam logic [23:0] C_H_DENS_OFF = 24'd1006633;
	localparam logic [23:0] C_H_DENS_MUL = 24'd14763950;
	localparam logic [23:0] C_H_OFFBEAT  = 24'd2348810;
	localparam logic [23:0] C_H_DENS     = 24'd6710886;
	localparam logic [23:0] C_H_SCALE0   = 24'd9227469;
	localparam logic [23:0] C_H_SCALE1   = 24'd7549747;

	// History table entries already weighted by the Markov factor (0.56 kick, 0.60 hat)
	localparam logic [23:0] KICK_MARKOV [4] = '{
		24'((64'd9395241 * 64'd14092861) >> 24),
		24'((64'd9395241 * 64'd3858760) >> 24),
		24'((64'd9395241 * 64'd11240735) >> 24),
		24'((64'd9395241 * 64'd6543114) >> 24)
	};
	localparam logic [23:0] HAT_MARKOV [4] = '{
		24'((64'd10066330 * 64'd2013266) >> 24),
		24'((64'd10066330 * 64'd12079596) >> 24),
		24'((64'd10066330 * 64'd5704253) >> 24),
		24'((64'd10066330 * 64'd14428406) >> 24)
	};

	// Items
	typedef struct packed {
		logic        kind;
		logic [31:0] seed_time;
	} step_item_t;

	typedef struct packed {
		logic        kick_fire;
		logic        hat_fire;
		logic [3:0]  step_position;
		logic [23:0] hat_variation;
	} trig_item_t;

	// Clamped Q24 probability, 1.0 included
	typedef logic [24:0] prob_t;

	// kick: [accent][kick history]; hat: [kick fired][hat history][odd step]
	typedef logic [1:0][3:0][24:0]       kick_prob_tab_t;
	typedef logic [1:0][3:0][1:0][24:0]  hat_prob_tab_t;

	typedef struct packed {
		logic           settled;
		kick_prob_tab_t kick_p;
		hat_prob_tab_t  hat_p;
	} prob_set_t;

endpackage

`default_nettype wire

### src/mdtg_cfg.sv
// Knob registers and the registered pipeline that turns them into probability tables.
`default_nettype none

module mdtg_cfg (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [mdtg_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [mdtg_pkg::CFG_DATA_W-1:0]   cfg_data,
	output mdtg_pkg::prob_set_t                    probs
);

	logic [16:0] kick_knob_q;
	logic [16:0] hat_knob_q;
	logic [2:0]  settle_q;
	logic [16:0] cfg_sat;

	logic [24:0] kc;
	logic [24:0] hc;
	logic [48:0] kdm_prod;
	logic [48:0] hdm_prod;
	logic [48:0] ob_prod;
	logic [48:0] hs_prod;

	logic [23:0] kdm_s1;
	logic [23:0] hdm_s1;
	logic [23:0] ob_s1;
	logic [23:0] hs_s1;

	logic [24:0] kdens;
	logic [24:0] hdens;
	logic [48:0] kd_prod;
	logic [48:0] hd_prod;

	logic [23:0] kd_s2;
	logic [23:0] hd_s2;
	logic [23:0] ob_s2;
	logic [24:0] scale_s2;

	logic [1:0][3:0][25:0] kick_sum;
	logic [3:0][1:0][25:0] hat_sum;
	mdtg_pkg::kick_prob_tab_t kick_p_s3;
	logic [3:0][1:0][25:0]    hat_pre_s3;
	logic [24:0]              scale_s3;

	logic [3:0][1:0][50:0]    hat_scaled;
	mdtg_pkg::kick_prob_tab_t kick_p_s4;
	mdtg_pkg::hat_prob_tab_t  hat_p_s4;

	function automatic mdtg_pkg::prob_t clamp_one(logic [26:0] p);
		if (p > 27'(mdtg_pkg::Q_ONE)) begin
			return mdtg_pkg::Q_ONE;
		end
		return p[24:0];
	endfunction

	// Knob write, saturated at one
	assign cfg_sat = (cfg_data > mdtg_pkg::KNOB_MAX) ? mdtg_pkg::KNOB_MAX : cfg_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kick_knob_q <= mdtg_pkg::KICK_DENSITY_RST;
			hat_knob_q  <= mdtg_pkg::HAT_COMPLEXITY_RST;
		end else if (cfg_we) begin
			unique case (mdtg_pkg::cfg_reg_e'(cfg_index))
				mdtg_pkg::REG_KICK_DENSITY:   kick_knob_q <= cfg_sat;
				mdtg_pkg::REG_HAT_COMPLEXITY: hat_knob_q  <= cfg_sat;
				default: ;
			endcase
		end
	end

	// Settle counter: tables are stale until the pipeline has refilled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_q <= mdtg_pkg::SETTLE_CYCLES;
		end else if (cfg_we) begin
			settle_q <= mdtg_pkg::SETTLE_CYCLES;
		end else if (settle_q != 3'd0) begin
			settle_q <= settle_q - 3'd1;
		end
	end

	// Stage 1: knob products
	assign kc       = {kick_knob_q, 8'd0};
	assign hc       = {hat_knob_q, 8'd0};
	assign kdm_prod = 49'(mdtg_pkg::C_K_DENS_MUL) * 49'(kc);
	assign hdm_prod = 49'(mdtg_pkg::C_H_DENS_MUL) * 49'(hc);
	assign ob_prod  = 49'(mdtg_pkg::C_H_OFFBEAT) * 49'(hc);
	assign hs_prod  = 49'(mdtg_pkg::C_H_SCALE1) * 49'(hc);

	always_ff @(posedge clk) begin
		kdm_s1 <= kdm_prod[47:24];
		hdm_s1 <= hdm_prod[47:24];
		ob_s1  <= ob_prod[47:24];
		hs_s1  <= hs_prod[47:24];
	end

	// Stage 2: density terms and the hat scale for kick steps
	assign kdens   = 25'(mdtg_pkg::C_K_DENS_OFF) + 25'(kdm_s1);
	assign hdens   = 25'(mdtg_pkg::C_H_DENS_OFF) + 25'(hdm_s1);
	assign kd_prod = 49'(mdtg_pkg::C_K_DENS) * 49'(kdens);
	assign hd_prod = 49'(mdtg_pkg::C_H_DENS) * 49'(hdens);

	always_ff @(posedge clk) begin
		kd_s2    <= kd_prod[47:24];
		hd_s2    <= hd_prod[47:24];
		ob_s2    <= ob_s1;
		scale_s2 <= 25'(mdtg_pkg::C_H_SCALE0) + 25'(hs_s1);
	end

	// Stage 3: per-history sums
	always_comb begin
		for (int h = 0; h < 4; h++) begin
			for (int a = 0; a < 2; a++) begin
				kick_sum[a][h] = 26'(mdtg_pkg::KICK_MARKOV[h]) + 26'(kd_s2)
					+ ((a == 1) ? 26'(mdtg_pkg::C_K_ACCENT) : 26'd0);
				hat_sum[h][a]  = 26'(mdtg_pkg::HAT_MARKOV[h]) + 26'(hd_s2)
					+ ((a == 1) ? 26'(ob_s2) : 26'd0);
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int h = 0; h < 4; h++) begin
			for (int a = 0; a < 2; a++) begin
				kick_p_s3[a][h] <= clamp_one(27'(kick_sum[a][h]));
			end
		end
		hat_pre_s3 <= hat_sum;
		scale_s3   <= scale_s2;
	end

	// Stage 4: hat probabilities, plain and scaled for a kick step
	always_comb begin
		for (int h = 0; h < 4; h++) begin
			for (int o = 0; o < 2; o++) begin
				hat_scaled[h][o] = 51'(hat_pre_s3[h][o]) * 51'(scale_s3);
			end
		end
	end

	always_ff @(posedge clk) begin
		kick_p_s4 <= kick_p_s3;
		for (int h = 0; h < 4; h++) begin
			for (int o = 0; o < 2; o++) begin
				hat_p_s4[0][h][o] <= clamp_one(27'(hat_pre_s3[h][o]));
				hat_p_s4[1][h][o] <= clamp_one(hat_scaled[h][o][50:24]);
			end
		end
	end

	assign probs.settled = (settle_q == 3'd0);
	assign probs.kick_p  = kick_p_s4;
	assign probs.hat_p   = hat_p_s4;

endmodule

`default_nettype wire

### src/mdtg_step.sv
// Sequencer state, random draws, trigger decisions and the result register.
`default_nettype none

module mdtg_step (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire mdtg_pkg::prob_set_t  probs,
	input  wire logic                 step_valid,
	output logic                      step_ready,
	input  wire mdtg_pkg::step_item_t step_item,
	output logic                      trig_valid,
	input  wire logic                 trig_ready,
	output mdtg_pkg::trig_item_t      trig_item
);

	logic [31:0] gen_q;
	logic [1:0]  khist_q;
	logic [1:0]  hhist_q;
	logic [3:0]  step_q;
	logic        trig_valid_q;
	mdtg_pkg::trig_item_t trig_q;

	logic        accept;
	logic [3:0]  step_nx;
	logic [31:0] d1;
	logic [31:0] d2;
	logic [31:0] d3;
	logic        accent;
	mdtg_pkg::prob_t kp;
	mdtg_pkg::prob_t hp;
	logic        kick;
	logic        hat;
	logic [31:0] reseed_gen;

	function automatic logic [31:0] xorshift32(logic [31:0] v);
		logic [31:0] x;
		x = v;
		x = x ^ (x << 13);
		x = x ^ (x >> 17);
		x = x ^ (x << 5);
		return x;
	endfunction

	// Take a new item when the tables are settled and the output register is free or being emptied
	assign step_ready = probs.settled && (!trig_valid_q || trig_ready);
	assign accept     = step_valid && step_ready;

	// Three chained draws; the third is used only on a hat trigger
	assign step_nx = step_q + 4'd1;
	assign d1      = xorshift32(gen_q);
	assign d2      = xorshift32(d1);
	assign d3      = xorshift32(d2);

	// Kick decision, accent on every fourth step
	assign accent = (step_nx[1:0] == 2'b00);
	assign kp     = probs.kick_p[accent][khist_q];
	assign kick   = {1'b0, d1[23:0]} < kp;

	// Hat decision: offbeat bonus on odd steps, table picks scaled entry on a kick
	assign hp  = probs.hat_p[kick][hhist_q][step_nx[0]];
	assign hat = {1'b0, d2[23:0]} < hp;

	// Reseed value
	assign reseed_gen = mdtg_pkg::MIX_XOR ^ (step_item.seed_time * mdtg_pkg::LCG_MUL
		+ mdtg_pkg::LCG_ADD);

	// State update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_q   <= mdtg_pkg::GEN_RESET;
			khist_q <= 2'd0;
			hhist_q <= 2'd0;
			step_q  <= 4'd15;
		end else if (accept) begin
			if (step_item.kind) begin
				gen_q   <= reseed_gen;
				khist_q <= 2'd0;
				hhist_q <= 2'd0;
			end else begin
				gen_q   <= hat ? d3 : d2;
				khist_q <= {khist_q[0], kick};
				hhist_q <= {hhist_q[0], hat};
				step_q  <= step_nx;
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trig_valid_q <= 1'b0;
		end else if (accept) begin
			trig_valid_q <= 1'b1;
		end else if (trig_ready) begin
			trig_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (step_item.kind) begin
				trig_q.kick_fire     <= 1'b0;
				trig_q.hat_fire      <= 1'b0;
				trig_q.step_position <= step_q;
				trig_q.hat_variation <= 24'd0;
			end else begin
				trig_q.kick_fire     <= kick;
				trig_q.hat_fire      <= hat;
				trig_q.step_position <= step_nx;
				trig_q.hat_variation <= hat ? d3[23:0] : 24'd0;
			end
		end
	end

	assign trig_valid = trig_valid_q;
	assign trig_item  = trig_q;

endmodule

`default_nettype wire

### src/markov_drum_trigger_generator_unit.sv
// Top level of the Markov drum trigger generator.
//
// Channels: step_* carries items in (a step tick, or a reseed with a time
// value); trig_* carries one result item out for every item taken, with the
// kick and hat triggers, the step position and the hat pitch variation.
// Both use valid/ready. cfg_we/cfg_index/cfg_data write the two knobs.
// Latency: a result is valid the cycle after its item is taken.
// Throughput: one item per cycle while step_ready is high. Generator,
// histories and step counter are updated in the cycle an item is taken, all
// draws and compares fitting in that same cycle; the knob-dependent products
// sit in a four-stage table pipeline that is off the item path.
// After reset and after every knob write, step_ready stays low while the
// probability tables refill.
// When the receiver stalls, the result is held in the output register and a
// new item is taken only in the cycle that result leaves.
`default_nettype none

module markov_drum_trigger_generator_unit (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [mdtg_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [mdtg_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  wire logic                              step_valid,
	output logic                                   step_ready,
	input  wire mdtg_pkg::step_item_t              step_item,
	output logic                                   trig_valid,
	input  wire logic                              trig_ready,
	output mdtg_pkg::trig_item_t                   trig_item
);

	mdtg_pkg::prob_set_t probs;

	// Knobs and probability tables
	mdtg_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.probs     (probs)
	);

	// Per-item sequencer
	mdtg_step u_step (
		.clk        (clk),
		.arst_n     (arst_n),
		.probs      (probs),
		.step_valid (step_valid),
		.step_ready (step_ready),
		.step_item  (step_item),
		.trig_valid (trig_valid),
		.trig_ready (trig_ready),
		.trig_item  (trig_item)
	);

endmodule

`default_nettype wire

### src/mdtg_checker.sv
// Port-level checker of the drum trigger generator, bound to the top level.
`default_nettype none

`include "markov_drum_trigger_generator_unit_assert.svh"

module mdtg_checker (
	input wire logic                              clk,
	input wire logic                              arst_n,
	input wire logic                              cfg_we,
	input wire logic                              step_valid,
	input wire logic                              step_ready,
	input wire mdtg_pkg::step_item_t              step_item,
	input wire logic                              trig_valid,
	input wire logic                              trig_ready,
	input wire mdtg_pkg::trig_item_t              trig_item
);

	logic no_hat_shown;
	logic var_zero;
	logic reseed_taken;
	logic trig_silent;
	logic trig_stalled;

	assign no_hat_shown = trig_valid && !trig_item.hat_fire;
	assign var_zero     = (trig_item.hat_variation == 24'd0);
	assign reseed_taken = step_valid && step_ready && step_item.kind;
	assign trig_silent  = !trig_item.kick_fire && !trig_item.hat_fire && var_zero;
	assign trig_stalled = trig_valid && !trig_ready;

	// No pitch variation without a hat
	`MDTG_ASSERT_IMP(a_var_needs_hat, clk, arst_n, no_hat_shown, var_zero, "hat variation without hat")

	// A reseed yields a silent result in the next cycle
	`MDTG_ASSERT_NXT(a_reseed_silent, clk, arst_n, reseed_taken, trig_valid && trig_silent, "reseed not silent")

	// Tables refill after a knob write, so no item is taken right after it
	`MDTG_ASSERT_NXT(a_cfg_settle, clk, arst_n, cfg_we, !step_ready, "item taken while tables settle")

	// A stalled result holds
	`MDTG_ASSERT_NXT(a_trig_hold, clk, arst_n, trig_stalled, trig_valid && $stable(trig_item), "result changed")

endmodule

bind markov_drum_trigger_generator_unit mdtg_checker u_mdtg_checker (.*);

`default_nettype wire

### dv/markov_drum_trigger_generator_unit_tb.sv
// Self-checking testbench for the Markov drum trigger generator unit.
module markov_drum_trigger_generator_unit_tb;

	localparam int IDLE_LIMIT = 5000;
	localparam int HOLD_CYCLES = 80;

	// History tables and Markov weights, Q24
	localparam logic [63:0] KICK_TAB [4] = '{64'd14092861, 64'd3858760, 64'd11240735,
		64'd6543114};
	localparam logic [63:0] HAT_TAB [4] = '{64'd2013266, 64'd12079596, 64'd5704253,
		64'd14428406};
	localparam logic [63:0] KICK_MARKOV_W = 64'd9395241;
	localparam logic [63:0] HAT_MARKOV_W = 64'd10066330;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [mdtg_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [mdtg_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	logic step_valid = 1'b0;
	logic step_ready;
	mdtg_pkg::step_item_t step_item = '0;
	logic trig_valid;
	logic trig_ready = 1'b0;
	mdtg_pkg::trig_item_t trig_item;

	// Predicted block state
	logic [31:0] gen_word = mdtg_pkg::GEN_RESET;
	logic [1:0] kick_hist = '0;
	logic [1:0] hat_hist = '0;
	logic [3:0] step_count = 4'd15;
	logic [16:0] kick_knob = mdtg_pkg::KICK_DENSITY_RST;
	logic [16:0] hat_knob = mdtg_pkg::HAT_COMPLEXITY_RST;

	mdtg_pkg::trig_item_t pending_triggers[$];
	int mismatch_count = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_reqs = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int quiet_cycles = 0;

	markov_drum_trigger_generator_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.step_valid(step_valid),
		.step_ready(step_ready),
		.step_item(step_item),
		.trig_valid(trig_valid),
		.trig_ready(trig_ready),
		.trig_item(trig_item)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Q24 product, truncated
	function automatic logic [63:0] q24_mul(logic [63:0] a, logic [63:0] b);
		return (a * b) >> 24;
	endfunction

	// Knob to Q24, saturating at one
	function automatic logic [63:0] knob_q24(logic [16:0] k);
		logic [16:0] sat;
		sat = (k > mdtg_pkg::KNOB_MAX) ? mdtg_pkg::KNOB_MAX : k;
		return {39'd0, sat, 8'd0};
	endfunction

	function automatic logic [63:0] clamp_q24(logic [63:0] p);
		return (p > 64'(mdtg_pkg::Q_ONE)) ? 64'(mdtg_pkg::Q_ONE) : p;
	endfunction

	// xorshift32 advance, low 24 bits out
	function automatic logic [23:0] draw_word();
		logic [31:0] x;
		x = gen_word;
		x = x ^ (x << 13);
		x = x ^ (x >> 17);
		x = x ^ (x << 5);
		gen_word = x;
		return x[23:0];
	endfunction

	// Advances the predicted state by one item and returns the trigger it causes
	function automatic mdtg_pkg::trig_item_t next_trigger(mdtg_pkg::step_item_t it);
		mdtg_pkg::trig_item_t r;
		logic [63:0] dens, pk, ph, hq;
		logic kick, hat;
		r = '0;
		if (it.kind) begin
			gen_word = mdtg_pkg::MIX_XOR
				^ (it.seed_time * mdtg_pkg::LCG_MUL + mdtg_pkg::LCG_ADD);
			kick_hist = '0;
			hat_hist = '0;
			r.step_position = step_count;
			return r;
		end
		step_count = step_count + 4'd1;

		// kick: history entry, density, downbeat accent
		dens = 64'(mdtg_pkg::C_K_DENS_OFF)
			+ q24_mul(64'(mdtg_pkg::C_K_DENS_MUL), knob_q24(kick_knob));
		pk = q24_mul(KICK_MARKOV_W, KICK_TAB[kick_hist])
			+ q24_mul(64'(mdtg_pkg::C_K_DENS), dens);
		if (step_count[1:0] == 2'd0) pk = pk + 64'(mdtg_pkg::C_K_ACCENT);
		pk = clamp_q24(pk);
		kick = {40'd0, draw_word()} < pk;

		// hat: history entry, complexity, offbeat bonus, scaled on kick
		hq = knob_q24(hat_knob);
		dens = 64'(mdtg_pkg::C_H_DENS_OFF) + q24_mul(64'(mdtg_pkg::C_H_DENS_MUL), hq);
		ph = q24_mul(HAT_MARKOV_W, HAT_TAB[hat_hist])
			+ q24_mul(64'(mdtg_pkg::C_H_DENS), dens);
		if (step_count[0]) ph = ph + q24_mul(64'(mdtg_pkg::C_H_OFFBEAT), hq);
		if (kick) ph = q24_mul(ph, 64'(mdtg_pkg::C_H_SCALE0)
			+ q24_mul(64'(mdtg_pkg::C_H_SCALE1), hq));
		ph = clamp_q24(ph);
		hat = {40'd0, draw_word()} < ph;
		if (hat) r.hat_variation = draw_word();

		kick_hist = {kick_hist[0], kick};
		hat_hist = {hat_hist[0], hat};
		r.kick_fire = kick;
		r.hat_fire = hat;
		r.step_position = step_count;
		return r;
	endfunction

	// Time value whose reseed leaves the generator at zero
	function automatic logic [31:0] zero_seed_time();
		logic [31:0] inv;
		inv = mdtg_pkg::LCG_MUL;
		// Newton iteration for the inverse mod 2^32
		repeat (5) inv = inv * (32'd2 - mdtg_pkg::LCG_MUL * inv);
		return (mdtg_pkg::MIX_XOR - mdtg_pkg::LCG_ADD) * inv;
	endfunction

	task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
		$display("ERROR %0t: %s got %0h expected %0h", $realtime, field, got, want);
		mismatch_count++;
	endtask

	// Model update on register writes and accepted items
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we) begin
				case (cfg_index)
					mdtg_pkg::REG_KICK_DENSITY: kick_knob = cfg_data;
					mdtg_pkg::REG_HAT_COMPLEXITY: hat_knob = cfg_data;
					default: ;
				endcase
			end
			if (step_valid && step_ready) pending_triggers.push_back(next_trigger(step_item));
		end
	end

	// Result checker
	always @(posedge clk) begin
		mdtg_pkg::trig_item_t want;
		if (arst_n && trig_valid && trig_ready) begin
			if (pending_triggers.size() == 0) begin
				report_mismatch("unexpected item", 32'(trig_item), 32'd0);
			end else begin
				want = pending_triggers.pop_front();
				if (trig_item.kick_fire !== want.kick_fire)
					report_mismatch("kick_fire", 32'(trig_item.kick_fire), 32'(want.kick_fire));
				if (trig_item.hat_fire !== want.hat_fire)
					report_mismatch("hat_fire", 32'(trig_item.hat_fire), 32'(want.hat_fire));
				if (trig_item.step_position !== want.step_position)
					report_mismatch("step_position", 32'(trig_item.step_position),
						32'(want.step_position));
				if (trig_item.hat_variation !== want.hat_variation)
					report_mismatch("hat_variation", 32'(trig_item.hat_variation),
						32'(want.hat_variation));
			end
		end
	end

	// Receiver: random stalls, plus long hold-offs on request
	always @(posedge clk) begin
		if (hold_seen != hold_reqs) begin
			hold_seen <= hold_reqs;
			hold_left <= HOLD_CYCLES;
			trig_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			trig_ready <= 1'b0;
		end else begin
			trig_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// Watchdog on cycles with no item moving
	always @(posedge clk) begin
		if (arst_n) begin
			if ((step_valid && step_ready) || (trig_valid && trig_ready)) quiet_cycles <= 0;
			else quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= IDLE_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	// Offers one item and waits for it to be taken; valid stays high afterwards
	task automatic send_step(logic kind, logic [31:0] seed);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			step_valid <= 1'b0;
			@(posedge clk);
		end
		step_valid <= 1'b1;
		step_item <= '{kind: kind, seed_time: seed};
		@(posedge clk);
		while (!step_ready) @(posedge clk);
	endtask

	task automatic wait_drained();
		step_valid <= 1'b0;
		do @(posedge clk); while (pending_triggers.size() != 0);
	endtask

	// Only called with nothing in flight
	task automatic write_knobs(logic [16:0] kick_val, logic [16:0] hat_val);
		cfg_we <= 1'b1;
		cfg_index <= mdtg_pkg::REG_KICK_DENSITY;
		cfg_data <= kick_val;
		@(posedge clk);
		cfg_index <= mdtg_pkg::REG_HAT_COMPLEXITY;
		cfg_data <= hat_val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic test_power_on_steps();
		repeat (4) send_step(1'b0, $urandom);
		wait_drained();
	endtask

	// Reseed at both time extremes, steps after each
	task automatic test_reseed_clears();
		send_step(1'b1, 32'd0);
		send_step(1'b0, 32'hFFFF_FFFF);
		send_step(1'b1, 32'hFFFF_FFFF);
		send_step(1'b0, 32'd0);
		wait_drained();
	endtask

	// Generator stuck at zero: every draw is zero
	task automatic test_zero_generator();
		send_step(1'b1, zero_seed_time());
		repeat (3) send_step(1'b0, $urandom);
		wait_drained();
	endtask

	// Knobs at zero, at one, and above one (saturating)
	task automatic test_knob_extremes();
		write_knobs(17'd0, 17'd0);
		repeat (2) send_step(1'b0, $urandom);
		wait_drained();
		write_knobs(mdtg_pkg::KNOB_MAX, mdtg_pkg::KNOB_MAX);
		repeat (2) send_step(1'b0, $urandom);
		wait_drained();
		write_knobs(17'h1FFFF, 17'd65537);
		repeat (2) send_step(1'b0, $urandom);
		wait_drained();
	endtask

	task automatic test_random_traffic(int count, int idle_pct, int stall_pct);
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		repeat (count) send_step($urandom_range(0, 99) < 6, $urandom);
		wait_drained();
		send_idle_pct = 0;
		recv_stall_pct = 0;
	endtask

	// Receiver holds off while the sender keeps offering
	task automatic test_receiver_hold();
		send_idle_pct = 0;
		hold_reqs++;
		repeat (24) send_step($urandom_range(0, 9) == 0, $urandom);
		wait_drained();
	endtask

	// Sender waits for every result before the next item
	task automatic test_paused_sender();
		recv_stall_pct = 50;
		repeat (10) begin
			send_step($urandom_range(0, 4) == 0, $urandom);
			wait_drained();
		end
		recv_stall_pct = 0;
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_power_on_steps();
		test_reseed_clears();
		test_zero_generator();
		test_knob_extremes();

		write_knobs(mdtg_pkg::KICK_DENSITY_RST, mdtg_pkg::HAT_COMPLEXITY_RST);
		test_random_traffic(210, 0, 0);
		write_knobs(17'($urandom_range(0, 65536)), 17'($urandom_range(0, 65536)));
		test_random_traffic(210, 65, 0);
		write_knobs(mdtg_pkg::KNOB_MAX, 17'd0);
		test_random_traffic(210, 0, 65);
		write_knobs(17'($urandom_range(0, 131071)), 17'($urandom_range(0, 131071)));
		test_random_traffic(210, 20, 20);
		test_receiver_hold();
		test_paused_sender();

		wait_drained();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0 && pending_triggers.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end
endmodule

### files.f
+incdir+src
src/mdtg_pkg.sv
src/mdtg_cfg.sv
src/mdtg_step.sv
src/markov_drum_trigger_generator_unit.sv
src/mdtg_checker.sv
dv/markov_drum_trigger_generator_unit_tb.sv
